// ===== src/assert_macros.svh =====
// Assertion helpers used by hphd_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define HPHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

// ===== src/hphd_pkg.sv =====
`default_nettype none

package hphd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TICK_W   = 16;
  localparam int ADDR_W   = 10;
  localparam int SLOT_W   = 3;
  localparam int CMP_W    = 17;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Thresholds 0.8 and 0.7 of the peak, as exact ratios.
  localparam logic [CMP_W-1:0] UPPER_NUM = 17'd4;
  localparam logic [CMP_W-1:0] UPPER_DEN = 17'd5;
  localparam logic [CMP_W-1:0] LOWER_NUM = 17'd7;
  localparam logic [CMP_W-1:0] LOWER_DEN = 17'd10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] store_data;
    logic [ADDR_W-1:0]   store_address;
    logic                beat;
    logic [TICK_W-1:0]   beat_interval;
    logic [SLOT_W-1:0]   beat_slot;
    logic [SAMPLE_W-1:0] peak_level;
  } result_t;

endpackage

`default_nettype wire

// ===== src/hphd_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module hphd_core
  import hphd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5,
  parameter int STORE_DEPTH   = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  output result_t                  res_o
);

  localparam int HP_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SP_W = $clog2(STORE_DEPTH);
  localparam logic [HP_W-1:0] HP_LAST = HP_W'(HISTORY_DEPTH - 1);
  localparam logic [SP_W-1:0] SP_LAST = SP_W'(STORE_DEPTH - 1);

  logic [SAMPLE_W-1:0] peak_q, peak_d;
  logic                armed_q, armed_d;
  logic [TICK_W-1:0]   ticks_q, ticks_d;
  logic [HP_W-1:0]     hp_q, hp_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [TICK_W-1:0]   hist_q [HISTORY_DEPTH];

  logic [TICK_W-1:0]   tick_inc;
  logic [CMP_W-1:0]    s_ext, p_ext;
  logic                above_upper, below_lower, beat;
  logic [31:0]         sp_ext, hp_ext;

  always_comb begin
    peak_d   = (sample_i > peak_q) ? sample_i : peak_q;
    tick_inc = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + 1'b1;

    s_ext = CMP_W'(sample_i);
    p_ext = CMP_W'(peak_d);
    // s > floor(p*4/5)  <=>  5s > 4p;  s < floor(p*7/10)  <=>  10(s+1) <= 7p
    above_upper = (s_ext * UPPER_DEN) > (p_ext * UPPER_NUM);
    below_lower = ((s_ext + 1'b1) * LOWER_DEN) <= (p_ext * LOWER_NUM);

    beat    = above_upper && !armed_q;
    armed_d = armed_q || beat;
    if (below_lower && armed_d) begin
      armed_d = 1'b0;
    end

    ticks_d = beat ? '0 : tick_inc;
    hp_d    = hp_q;
    if (beat) begin
      hp_d = (hp_q == HP_LAST) ? '0 : hp_q + 1'b1;
    end
    sp_d = (sp_q == SP_LAST) ? '0 : sp_q + 1'b1;

    sp_ext = 32'(sp_q);
    hp_ext = 32'(hp_q);

    res_o.store_data    = sample_i;
    res_o.store_address = sp_ext[ADDR_W-1:0];
    res_o.beat          = beat;
    res_o.beat_interval = beat ? tick_inc : '0;
    res_o.beat_slot     = beat ? hp_ext[SLOT_W-1:0] : '0;
    res_o.peak_level    = peak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      armed_q <= 1'b0;
      ticks_q <= '0;
      hp_q    <= '0;
      sp_q    <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (step_i) begin
      peak_q  <= peak_d;
      armed_q <= armed_d;
      ticks_q <= ticks_d;
      hp_q    <= hp_d;
      sp_q    <= sp_d;
      if (beat) begin
        hist_q[hp_q] <= tick_inc;
      end
    end
  end

  `HPHD_ASSERT(a_beat_arms, step_i && beat |=> armed_q, "beat did not arm detector")
  `HPHD_ASSERT(a_hist_write, step_i && beat |=> hist_q[$past(hp_q)] == $past(tick_inc),
               "interval not written to history slot")
  `HPHD_ASSERT(a_peak_mono, 1'b1 |=> peak_q >= $past(peak_q), "running peak decreased")

endmodule

`default_nettype wire

// ===== src/heartbeat_peak_hysteresis_detector.sv =====
// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+----------------------------------------------
// in      | in  | in_valid_i / in_ready_o   | sample_i
// out     | out | out_valid_o / out_ready_i | store_data_o, store_address_o, beat_o,
//         |     |                        | beat_interval_o, beat_slot_o, peak_level_o
//
// One sample per cycle sustained while out_ready_i is held high. A sample taken into the
// input register goes through one pass of compare logic, which loads its result into the
// result register that drives out_valid_o; a stalled output can hold it in between.
// rst_ni clears peak, arm flag, tick counter, both ring pointers and the history.
// A stalled output holds its result; the input register keeps accepting while the
// result register is free or being drained in the same cycle.
`default_nettype none

module heartbeat_peak_hysteresis_detector
  import hphd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5,
  parameter int STORE_DEPTH   = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [SAMPLE_W-1:0]      store_data_o,
  output logic [ADDR_W-1:0]        store_address_o,
  output logic                     beat_o,
  output logic [TICK_W-1:0]        beat_interval_o,
  output logic [SLOT_W-1:0]        beat_slot_o,
  output logic [SAMPLE_W-1:0]      peak_level_o
);

  logic                in_vld_q;
  logic [SAMPLE_W-1:0] in_smp_q;
  logic                res_vld_q;
  result_t             res_q;
  result_t             core_res;
  logic                res_free, step;

  assign res_free   = !res_vld_q || out_ready_i;
  assign step       = in_vld_q && res_free;
  assign in_ready_o = !in_vld_q || step;

  hphd_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .STORE_DEPTH   (STORE_DEPTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (in_smp_q),
    .res_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_free) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_smp_q <= sample_i;
    end
    if (step) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o     = res_vld_q;
  assign store_data_o    = res_q.store_data;
  assign store_address_o = res_q.store_address;
  assign beat_o          = res_q.beat;
  assign beat_interval_o = res_q.beat_interval;
  assign beat_slot_o     = res_q.beat_slot;
  assign peak_level_o    = res_q.peak_level;

endmodule

`default_nettype wire
